// File: sv/trd_pkg.sv
`default_nettype none
package trd_pkg;

  localparam int ID_WIDTH   = 31;
  localparam int REC_ID_W   = 31;
  localparam int REC_LEN    = 31;
  localparam int REC_BITS   = REC_LEN * 8;
  localparam int CNT_W      = 5;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int QCNT_W     = $clog2(QDEPTH + 1);
  localparam int OUT_W      = 248;

  localparam logic [7:0]       HEADER_BYTE      = 8'h24;
  localparam logic [CNT_W-1:0] LAST_BYTE_IDX    = CNT_W'(REC_LEN - 1);
  localparam logic [31:0]      UNITS_PER_DEGREE = 32'd600000;

  typedef struct packed {
    logic [REC_ID_W-1:0] id;
    logic [REC_BITS-1:0] bytes;   // record byte 0 in the top byte
  } rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // nibble to digit value, codes above nine count seven more
  function automatic logic [4:0] dig(input logic [3:0] n);
    logic [4:0] v;
    v = (n < 4'd10) ? {1'b0, n} : ({1'b0, n} + 5'd7);
    return v;
  endfunction

  function automatic logic [7:0] dec2(input logic [7:0] v);
    logic [7:0] acc;
    acc = 8'(dig(v[7:4])) * 8'd10 + 8'(dig(v[3:0]));
    return acc;
  endfunction

  function automatic logic [11:0] dec3(input logic [11:0] v);
    logic [11:0] acc;
    acc = 12'd0;
    for (int i = 0; i < 3; i++) begin
      acc = acc * 12'd10 + 12'(dig(v[4*(2-i) +: 4]));
    end
    return acc;
  endfunction

  function automatic logic [21:0] dec6(input logic [23:0] v);
    logic [21:0] acc;
    acc = 22'd0;
    for (int i = 0; i < 6; i++) begin
      acc = acc * 22'd10 + 22'(dig(v[4*(5-i) +: 4]));
    end
    return acc;
  endfunction

endpackage
`default_nettype wire

// File: sv/trd_front.sv
`default_nettype none
module trd_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [7:0]                    in_byte,
  input  wire logic                          in_link_closed,
  output logic                               in_ready,
  input  wire logic                          cfg_we,
  input  wire logic [trd_pkg::REC_ID_W-1:0]  cfg_wdata,
  input  wire trd_pkg::q_stat_t              q_stat,
  output logic                               push,
  output trd_pkg::rec_t                      push_rec
);
  import trd_pkg::*;

  logic                capturing_r, capturing_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_WIDTH-1:0] last_id_r, last_id_nxt;
  logic [REC_BITS-1:0] bytes_r;
  logic                accept;
  logic [REC_BITS-1:0] bytes_shift;

  assign in_ready    = !q_stat.full;
  assign accept      = in_valid && in_ready;
  assign bytes_shift = {bytes_r[REC_BITS-9:0], in_byte};

  always_comb begin
    capturing_nxt = capturing_r;
    count_nxt     = count_r;
    last_id_nxt   = last_id_r;
    push          = 1'b0;
    if (cfg_we) begin
      last_id_nxt = ID_WIDTH'(cfg_wdata);
    end
    if (accept) begin
      if (in_link_closed) begin
        capturing_nxt = 1'b0;
        count_nxt     = '0;
      end else if (!capturing_r) begin
        if (in_byte == HEADER_BYTE) begin
          capturing_nxt = 1'b1;
          count_nxt     = '0;
        end
      end else if (count_r == LAST_BYTE_IDX) begin
        push          = 1'b1;
        capturing_nxt = 1'b0;
        count_nxt     = '0;
        last_id_nxt   = last_id_r + 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  assign push_rec.id    = REC_ID_W'(last_id_r + 1'b1);
  assign push_rec.bytes = bytes_shift;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capturing_r <= 1'b0;
      count_r     <= '0;
      last_id_r   <= '0;
    end else begin
      capturing_r <= capturing_nxt;
      count_r     <= count_nxt;
      last_id_r   <= last_id_nxt;
    end
  end

  // record shift line, only loaded with data bytes
  always_ff @(posedge clk) begin
    if (accept && capturing_r && !in_link_closed) begin
      bytes_r <= bytes_shift;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= LAST_BYTE_IDX)
    else $error("byte count past record end");
  a_hunt_count: assert property (@(posedge clk) disable iff (!rst_n)
    !capturing_r |-> count_r == '0)
    else $error("byte count not cleared while hunting");
  a_push_id: assert property (@(posedge clk) disable iff (!rst_n)
    push && !cfg_we |=> last_id_r == $past(last_id_r) + 1'b1)
    else $error("id not advanced on record");

endmodule
`default_nettype wire

// File: sv/trd_queue.sv
`default_nettype none
module trd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire trd_pkg::rec_t push_rec,
  input  wire logic          pop,
  output trd_pkg::rec_t      pop_rec,
  output trd_pkg::q_stat_t   q_stat
);
  import trd_pkg::*;

  rec_t              entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] fill_r;

  assign q_stat.full  = (fill_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (fill_r == '0);
  assign pop_rec      = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        fill_r <= fill_r + 1'b1;
      end else if (pop && !push) begin
        fill_r <= fill_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && q_stat.empty))
    else $error("pop from empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= QCNT_W'(QDEPTH))
    else $error("queue fill out of range");

endmodule
`default_nettype wire

// File: sv/trd_back.sv
`default_nettype none
module trd_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire trd_pkg::rec_t              q_rec,
  input  wire trd_pkg::q_stat_t           q_stat,
  output logic                            pop,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  output logic [trd_pkg::OUT_W-1:0]       out_tdata
);
  import trd_pkg::*;

  // decode stage
  logic                s1_v_r;
  logic [REC_ID_W-1:0] s1_id_r;
  logic [39:0]         s1_serial_r;
  logic [23:0]         s1_time_r, s1_date_r;
  logic [7:0]          s1_lat_deg_r;
  logic [21:0]         s1_lat_min_r, s1_lon_min_r;
  logic [11:0]         s1_lon_deg_r, s1_speed_r, s1_head_r;
  logic                s1_lat_neg_r, s1_lon_neg_r;
  logic [31:0]         s1_status_r;
  logic [7:0]          s1_alarm_r;

  // output register
  logic                out_v_r;
  logic [OUT_W-1:0]    out_data_r;

  logic                s2_ready, s1_take, s2_take;
  logic [3:0]          flag_nib;
  logic [31:0]         lat_mag, lon_mag, lat_val, lon_val;

  assign s2_ready = !out_v_r || out_tready;
  assign s2_take  = s1_v_r && s2_ready;
  assign s1_take  = !s1_v_r || s2_ready;
  assign pop      = s1_take && !q_stat.empty;
  assign flag_nib = q_rec.bytes[83:80];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_take) begin
        s1_v_r <= !q_stat.empty;
      end
      if (s2_ready) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_id_r      <= q_rec.id;
      s1_serial_r  <= q_rec.bytes[247:208];
      s1_time_r    <= q_rec.bytes[207:184];
      s1_date_r    <= q_rec.bytes[183:160];
      s1_lat_deg_r <= dec2(q_rec.bytes[159:152]);
      s1_lat_min_r <= dec6(q_rec.bytes[151:128]);
      s1_lon_deg_r <= dec3(q_rec.bytes[119:108]);
      s1_lon_min_r <= dec6(q_rec.bytes[107:84]);
      s1_lat_neg_r <= (flag_nib[2:0] == 3'd0);
      s1_lon_neg_r <= (flag_nib == 4'd0);
      s1_speed_r   <= dec3(q_rec.bytes[79:68]);
      s1_head_r    <= dec3(q_rec.bytes[67:56]);
      s1_status_r  <= q_rec.bytes[55:24];
      s1_alarm_r   <= q_rec.bytes[23:16];
    end
  end

  // degrees scaled to 1/10000 arcminute, then sign
  assign lat_mag = 32'(s1_lat_deg_r) * UNITS_PER_DEGREE + 32'(s1_lat_min_r);
  assign lon_mag = 32'(s1_lon_deg_r) * UNITS_PER_DEGREE + 32'(s1_lon_min_r);
  assign lat_val = s1_lat_neg_r ? (32'd0 - lat_mag) : lat_mag;
  assign lon_val = s1_lon_neg_r ? (32'd0 - lon_mag) : lon_mag;

  always_ff @(posedge clk) begin
    if (s2_take) begin
      out_data_r <= {4'd0, s1_alarm_r, s1_status_r, s1_head_r, s1_speed_r,
                     lon_val, lat_val[28:0], s1_date_r, s1_time_r,
                     s1_serial_r, s1_id_r};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

  a_pop_space: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!s1_v_r || s2_ready))
    else $error("pop with decode stage blocked");
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s2_ready |=> s1_v_r && $stable(s1_id_r))
    else $error("decode stage lost while stalled");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready |=> out_v_r)
    else $error("result dropped while stalled");

endmodule
`default_nettype wire

// File: sv/tracker_record_deframe_decode.sv
// channel  dir  handshake                 payload
// in_      in   in_tvalid / in_tready     in_tdata rx_byte, in_tuser link_closed
// out_     out  out_tvalid / out_tready   out_tdata decoded record
// cfg_     in   cfg_we                    cfg_wdata id_base
//
// one byte beat is taken every cycle while the record queue has a free slot
// out_tvalid rises once a record's last byte beat has passed, in order, the registers
// below; a stalled out_ side or older queued records can hold it on the way
// (queue write, decode stage, output register)
// synchronous active-low reset: hunting, no ids used, queue and pipeline empty
// the in_ side stalls only when two finished records wait in the queue
`default_nettype none
module tracker_record_deframe_decode (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [7:0]                 in_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]                 in_tuser,   // [0] link_closed
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // [30:0] record_id, [70:31] unit_serial, [94:71] fix_time,
  // [118:95] fix_date, [147:119] latitude_units, [179:148] longitude_units,
  // [191:180] speed_value, [203:192] heading_value, [235:204] status_word,
  // [243:236] alarm_byte, [247:244] zero
  output logic [trd_pkg::OUT_W-1:0]       out_tdata,
  input  wire logic                       cfg_we,
  input  wire logic [trd_pkg::REC_ID_W-1:0] cfg_wdata  // id_base
);
  import trd_pkg::*;

  // front to queue
  logic    push;
  rec_t    push_rec;
  // queue to back
  logic    pop;
  rec_t    pop_rec;
  q_stat_t q_stat;

  // header hunt, byte capture and id assignment
  trd_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_tvalid),
    .in_byte        (in_tdata),
    .in_link_closed (in_tuser[0]),
    .in_ready       (in_tready),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .q_stat         (q_stat),
    .push           (push),
    .push_rec       (push_rec)
  );

  // two-record queue decoupling capture from decode
  trd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  // digit decode, scaling and output register
  trd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_rec      (pop_rec),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// File: dv/tracker_record_deframe_decode_tb.sv
`timescale 1ns / 100ps
module tracker_record_deframe_decode_tb;
  import trd_pkg::*;

  // pause after the last result before the id register is touched,
  // covers the three-stage pipe behind the byte capture
  localparam int LAT_PAD        = 8;
  // cycles without any beat on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 4000;
  // random byte beats spread over the random phases
  localparam int RAND_BEATS     = 1100;
  localparam int RAND_PHASES    = 4;
  localparam int MAX_PRINTED    = 40;

  // record image as captured, index i holds record byte i
  typedef logic [REC_LEN-1:0][7:0] rec_image_t;

  // out_tdata layout, first member is the top of the word
  typedef struct packed {
    logic [3:0]          zero_pad;
    logic [7:0]          alarm_byte;
    logic [31:0]         status_word;
    logic [11:0]         heading_value;
    logic [11:0]         speed_value;
    logic [31:0]         longitude_units;
    logic [28:0]         latitude_units;
    logic [23:0]         fix_date;
    logic [23:0]         fix_time;
    logic [39:0]         unit_serial;
    logic [REC_ID_W-1:0] record_id;
  } decoded_rec_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [7:0] rx_byte
  logic [0:0]          in_tuser;   // [0] link_closed
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;  // decoded_rec_t, record_id in the low bits
  logic                cfg_we;
  logic [REC_ID_W-1:0] cfg_wdata;  // id_base

  tracker_record_deframe_decode uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // ---------------------------------------------------------------------
  // deframer mirror: hunt/capture state, captured bytes, ids handed out
  // ---------------------------------------------------------------------
  bit                  cap_active;
  int                  cap_fill;
  rec_image_t          cap_img;
  logic [REC_ID_W-1:0] ids_used;
  decoded_rec_t        decoded_q[$];   // decoded records still to come out

  int                  mismatch_count;
  int                  burst_left;
  int                  beats_sent;

  // nibble codes above nine count seven more
  function automatic int unsigned nibble_value(input logic [3:0] n);
    return (n < 4'd10) ? int'(n) : int'(n) + 7;
  endfunction

  // decimal value of a run of nibbles, nibble 2k is the high half of byte k
  function automatic int unsigned digit_run(input rec_image_t img, input int first,
                                            input int count);
    int unsigned acc;
    logic [7:0]  b;
    logic [3:0]  n;
    acc = 0;
    for (int i = first; i < first + count; i++) begin
      b   = img[i >> 1];
      n   = (i % 2 == 0) ? b[7:4] : b[3:0];
      acc = acc * 10 + nibble_value(n);
    end
    return acc;
  endfunction

  function automatic decoded_rec_t decode_record(input rec_image_t img,
                                                 input logic [REC_ID_W-1:0] id);
    decoded_rec_t r;
    longint       lat;
    longint       lon;
    // latitude: two degree digits at byte 11, six minute digits after them
    lat = longint'(digit_run(img, 22, 2)) * longint'(UNITS_PER_DEGREE)
        + longint'(digit_run(img, 24, 6));
    // longitude: three degree digits at byte 16, six minute digits after them
    lon = longint'(digit_run(img, 32, 3)) * longint'(UNITS_PER_DEGREE)
        + longint'(digit_run(img, 35, 6));
    // hemisphere flags live in the low nibble of byte 20
    if (img[20][3:0] == 4'h0) lon = -lon;
    if (img[20][2:0] == 3'h0) lat = -lat;
    r.zero_pad        = '0;
    r.record_id       = id;
    r.unit_serial     = {img[0], img[1], img[2], img[3], img[4]};
    r.fix_time        = {img[5], img[6], img[7]};
    r.fix_date        = {img[8], img[9], img[10]};
    r.latitude_units  = lat[28:0];
    r.longitude_units = lon[31:0];
    r.speed_value     = 12'(digit_run(img, 42, 3));
    r.heading_value   = 12'(digit_run(img, 45, 3));
    r.status_word     = {img[24], img[25], img[26], img[27]};
    r.alarm_byte      = img[28];
    return r;
  endfunction

  // advance the mirror by one accepted byte beat
  task automatic predict_beat(input logic [7:0] b, input logic closed);
    if (closed) begin
      // link gone: byte ignored, partial record dropped
      cap_active = 1'b0;
      cap_fill   = 0;
    end else if (!cap_active) begin
      if (b == HEADER_BYTE) begin
        cap_active = 1'b1;
        cap_fill   = 0;
      end
    end else begin
      // a header byte during capture is plain data
      cap_img[cap_fill] = b;
      cap_fill++;
      if (cap_fill == REC_LEN) begin
        cap_active = 1'b0;
        cap_fill   = 0;
        ids_used   = ids_used + 1'b1;   // wraps at the id width
        decoded_q.push_back(decode_record(cap_img, ids_used));
      end
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("%0t: %s got %h want %h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------
  // clock, 10 ns period
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // byte sender: bursts of random length, random gaps in between,
  // changes only on the falling edge
  // ---------------------------------------------------------------------
  task automatic send_beat(input logic [7:0] b, input logic closed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= closed;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    predict_beat(b, closed);
  endtask

  // header then the record bytes; a cut position swaps that byte for a link drop
  task automatic send_record(input rec_image_t img, input int cut_at);
    send_beat(HEADER_BYTE, 1'b0);
    for (int i = 0; i < REC_LEN; i++) begin
      if (i == cut_at) begin
        send_beat(8'($urandom), 1'b1);
        return;
      end
      send_beat(img[i], 1'b0);
    end
  endtask

  // mostly plausible BCD content, sometimes any nibble, flags often forced
  function automatic rec_image_t random_record();
    rec_image_t img;
    int         style;
    bit         bcd;
    style = $urandom_range(0, 3);
    for (int i = 0; i < REC_LEN; i++) begin
      bcd = (style <= 1) ? 1'b1 : (style == 2) ? 1'b0 : 1'($urandom);
      if (bcd) img[i] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      else     img[i] = 8'($urandom);
    end
    case ($urandom_range(0, 3))
      0: img[20][3:0] = 4'h0;   // both hemispheres flipped
      1: img[20][3:0] = 4'h8;   // latitude only
      default: ;
    endcase
    return img;
  endfunction

  // stop sending, let every record out, then give the pipe time to settle
  task automatic drain_records();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (LAT_PAD) @(posedge clk);
  endtask

  // id register is only written with the block idle
  task automatic write_id_base(input logic [REC_ID_W-1:0] base);
    drain_records();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    ids_used = base;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // receiver: own pattern of always-ready, light stalls and long stalls
  // ---------------------------------------------------------------------
  initial begin
    int mode;
    int span;
    out_tready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(0, 3) != 0);
          default: out_tready <= ($urandom_range(0, 15) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // result checker: every out beat against the oldest decoded record
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    decoded_rec_t got;
    decoded_rec_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (decoded_q.size() == 0) begin
        report_mismatch("record with none pending, id", 64'(got.record_id), 64'd0);
      end else begin
        want = decoded_q.pop_front();
        if (got.record_id !== want.record_id)
          report_mismatch("record_id", 64'(got.record_id), 64'(want.record_id));
        if (got.unit_serial !== want.unit_serial)
          report_mismatch("unit_serial", 64'(got.unit_serial), 64'(want.unit_serial));
        if (got.fix_time !== want.fix_time)
          report_mismatch("fix_time", 64'(got.fix_time), 64'(want.fix_time));
        if (got.fix_date !== want.fix_date)
          report_mismatch("fix_date", 64'(got.fix_date), 64'(want.fix_date));
        if (got.latitude_units !== want.latitude_units)
          report_mismatch("latitude_units", 64'(got.latitude_units),
                          64'(want.latitude_units));
        if (got.longitude_units !== want.longitude_units)
          report_mismatch("longitude_units", 64'(got.longitude_units),
                          64'(want.longitude_units));
        if (got.speed_value !== want.speed_value)
          report_mismatch("speed_value", 64'(got.speed_value), 64'(want.speed_value));
        if (got.heading_value !== want.heading_value)
          report_mismatch("heading_value", 64'(got.heading_value),
                          64'(want.heading_value));
        if (got.status_word !== want.status_word)
          report_mismatch("status_word", 64'(got.status_word), 64'(want.status_word));
        if (got.alarm_byte !== want.alarm_byte)
          report_mismatch("alarm_byte", 64'(got.alarm_byte), 64'(want.alarm_byte));
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: too long without a beat on either side ends the run
  // ---------------------------------------------------------------------
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  // junk while hunting, a dropped header, then an all-zero record
  // (both flags set on a zero position, negation of nothing)
  task automatic test_hunting_noise();
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h23, 1'b0);
    send_beat(HEADER_BYTE, 1'b1);   // header with the link closed is ignored
    send_beat(8'h25, 1'b0);
    send_record({REC_LEN{8'h00}}, -1);
  endtask

  // digit extremes and every flag combination, back to back records
  task automatic test_digit_extremes();
    rec_image_t img;
    // top nibble codes everywhere, flag nibble F keeps both signs
    send_record({REC_LEN{8'hFF}}, -1);
    // largest plain BCD with both hemispheres flipped
    img     = {REC_LEN{8'h99}};
    img[20] = 8'h90;
    send_record(img, -1);
    // latitude flipped, longitude kept
    img[20] = 8'h98;
    send_record(img, -1);
    // header bytes as record content
    send_record({REC_LEN{HEADER_BYTE}}, -1);
    // neither flipped, then a stray byte after the record before the next one
    img     = {REC_LEN{8'h12}};
    img[20] = 8'h31;
    send_record(img, -1);
    send_beat(8'h00, 1'b0);
    send_record(random_record(), -1);
  endtask

  // link drops mid record, straight after the header, on the last byte, while hunting
  task automatic test_link_drop();
    send_record(random_record(), 10);
    send_record(random_record(), 0);
    send_record(random_record(), REC_LEN - 1);
    send_beat(HEADER_BYTE, 1'b1);
    send_record(random_record(), -1);
  endtask

  // id counter at the top of its range, wrap to zero, then back to the bottom
  task automatic test_id_wrap();
    write_id_base(31'h7FFF_FFFE);
    send_record(random_record(), -1);
    send_record(random_record(), -1);
    write_id_base('0);
    send_record(random_record(), -1);
  endtask

  // mostly whole records with random content, some broken ones and noise
  task automatic test_random_traffic(input logic [REC_ID_W-1:0] base, input int beats);
    int target;
    int pick;
    write_id_base(base);
    target = beats_sent + beats;
    while (beats_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        send_record(random_record(), -1);
      else if (pick < 82)
        send_record(random_record(), $urandom_range(0, REC_LEN - 1));
      else if (pick < 92)
        repeat ($urandom_range(1, 4)) send_beat(8'($urandom), 1'b0);
      else
        send_beat(8'($urandom), 1'b1);
    end
  endtask

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    cap_active     = 1'b0;
    cap_fill       = 0;
    cap_img        = '0;
    ids_used       = '0;
    mismatch_count = 0;
    burst_left     = 0;
    beats_sent     = 0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_hunting_noise();
    test_digit_extremes();
    test_link_drop();
    test_id_wrap();
    test_random_traffic(REC_ID_W'($urandom), RAND_BEATS / RAND_PHASES);
    test_random_traffic(31'h7FFF_FFF0, RAND_BEATS / RAND_PHASES);   // base near the top of the id range
    test_random_traffic('0, RAND_BEATS / RAND_PHASES);
    test_random_traffic(REC_ID_W'($urandom), RAND_BEATS / RAND_PHASES);

    drain_records();
    if (mismatch_count == 0 && decoded_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
sv/trd_pkg.sv
sv/trd_front.sv
sv/trd_queue.sv
sv/trd_back.sv
sv/tracker_record_deframe_decode.sv
dv/tracker_record_deframe_decode_tb.sv
